@@ sv/cpa_pkg.sv @@
`default_nettype none

package cpa_pkg;

  localparam int SAMPLE_WIDTH        = 24;
  localparam int ANGLE_FRACTION_BITS = 23;

  // Samples are scaled up so that the top of the input sits just under bit 57.
  localparam int GUARD_BITS = 58 - SAMPLE_WIDTH;
  localparam int ITERATIONS = 32;
  localparam int IDX_W      = $clog2(ITERATIONS);

  // After prerotation |x|,|y| <= 2^57.5; the CORDIC gain keeps them under 2^59.
  localparam int XY_W = 60;
  // Angle accumulator in units of pi * 2^-31; the largest value stays under 2^32.
  localparam int Z_W  = 33;
  localparam int ZR_W = Z_W + 1;

  localparam int PHASE_W     = ANGLE_FRACTION_BITS + 2;
  localparam int IN_DATA_W   = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((PHASE_W + 7) / 8) * 8;
  localparam int ROUND_SHIFT = 31 - ANGLE_FRACTION_BITS;
  localparam int ROUND_HALF  = (ROUND_SHIFT > 0) ? (1 << (ROUND_SHIFT - 1)) : 0;

  localparam logic signed [PHASE_W-1:0] PI_PHASE = {2'b01, {ANGLE_FRACTION_BITS{1'b0}}};
  localparam logic signed [PHASE_W-1:0] HALF_PI_PHASE =
    {3'b001, {(ANGLE_FRACTION_BITS - 1){1'b0}}};
  localparam logic signed [Z_W-1:0] Z_QUARTER = {{(Z_W - 31){1'b0}}, 1'b1, 30'b0};

  // atan(2^-i) / pi * 2^31, rounded.
  localparam logic [29:0] ATAN_TABLE [ITERATIONS] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4,
    30'h028B0D43, 30'h0145D7E1, 30'h00A2F61E, 30'h00517C55,
    30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
    30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D,
    30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
    30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051,
    30'h00000029, 30'h00000014, 30'h0000000A, 30'h00000005,
    30'h00000003, 30'h00000001, 30'h00000001, 30'h00000000
  };

  typedef enum logic [2:0] {
    SP_NONE,
    SP_ZERO,
    SP_PI,
    SP_POS_HALF,
    SP_NEG_HALF
  } special_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    special_t               special;
  } vec_t;

endpackage

`default_nettype wire

@@ sv/cpa_prerot.sv @@
`default_nettype none

module cpa_prerot (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [cpa_pkg::SAMPLE_WIDTH-1:0] re,
  input  logic signed [cpa_pkg::SAMPLE_WIDTH-1:0] im,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output cpa_pkg::vec_t                          out_vec
);
  import cpa_pkg::*;

  logic                   valid_r;
  vec_t                   vec_r;
  vec_t                   vec_nxt;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;

  assign xs = XY_W'(re) <<< GUARD_BITS;
  assign ys = XY_W'(im) <<< GUARD_BITS;

  // Samples in the left half plane are turned by a quarter turn so that the
  // iterations only have to cover the right half plane.
  always_comb begin
    vec_nxt.x = xs;
    vec_nxt.y = ys;
    vec_nxt.z = '0;
    if (re < 0) begin
      if (im >= 0) begin
        vec_nxt.x = ys;
        vec_nxt.y = -xs;
        vec_nxt.z = Z_QUARTER;
      end else begin
        vec_nxt.x = -ys;
        vec_nxt.y = xs;
        vec_nxt.z = -Z_QUARTER;
      end
    end
    if (im == 0) begin
      vec_nxt.special = (re < 0) ? SP_PI : SP_ZERO;
    end else if (re == 0) begin
      vec_nxt.special = (im > 0) ? SP_POS_HALF : SP_NEG_HALF;
    end else begin
      vec_nxt.special = SP_NONE;
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_vec   = vec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      vec_r <= vec_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/cpa_cell.sv @@
`default_nettype none

module cpa_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [cpa_pkg::IDX_W-1:0] idx,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  cpa_pkg::vec_t             in_vec,
  output logic                      out_valid,
  input  logic                      out_ready,
  output cpa_pkg::vec_t             out_vec
);
  import cpa_pkg::*;

  logic                   valid_r;
  vec_t                   vec_r;
  vec_t                   vec_nxt;
  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic signed [Z_W-1:0]  step;

  // The index is tied to a constant per cell, so the shifts reduce to wiring.
  assign dx   = $signed(in_vec.y) >>> idx;
  assign dy   = $signed(in_vec.x) >>> idx;
  assign step = $signed(Z_W'(ATAN_TABLE[idx]));

  always_comb begin
    vec_nxt.special = in_vec.special;
    if ($signed(in_vec.y) > 0) begin
      vec_nxt.x = in_vec.x + dx;
      vec_nxt.y = in_vec.y - dy;
      vec_nxt.z = in_vec.z + step;
    end else begin
      vec_nxt.x = in_vec.x - dx;
      vec_nxt.y = in_vec.y + dy;
      vec_nxt.z = in_vec.z - step;
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_vec   = vec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      vec_r <= vec_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/cpa_round.sv @@
`default_nettype none

module cpa_round (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  cpa_pkg::vec_t               in_vec,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cpa_pkg::PHASE_W-1:0] phase
);
  import cpa_pkg::*;

  logic                      valid_r;
  logic [PHASE_W-1:0]        phase_r;
  logic [PHASE_W-1:0]        phase_nxt;
  logic signed [ZR_W-1:0]    zsum;
  logic signed [ZR_W-1:0]    zq;
  logic signed [ZR_W-1:0]    pi_ext;
  logic signed [PHASE_W-1:0] sat;

  assign zsum   = ZR_W'(in_vec.z) + ZR_W'(ROUND_HALF);
  assign zq     = zsum >>> ROUND_SHIFT;
  assign pi_ext = ZR_W'(PI_PHASE);

  // Residual error of the iterations can step just past the cut at pi.
  always_comb begin
    if (zq > pi_ext) begin
      sat = PI_PHASE;
    end else if (zq < -pi_ext) begin
      sat = -PI_PHASE;
    end else begin
      sat = zq[PHASE_W-1:0];
    end
  end

  always_comb begin
    case (in_vec.special)
      SP_NONE:     phase_nxt = sat;
      SP_ZERO:     phase_nxt = '0;
      SP_PI:       phase_nxt = PI_PHASE;
      SP_POS_HALF: phase_nxt = HALF_PI_PHASE;
      SP_NEG_HALF: phase_nxt = -HALF_PI_PHASE;
      default:     phase_nxt = '0;
    endcase
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign phase     = phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      phase_r <= phase_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/complex_phase_angle.sv @@
// Four-quadrant phase angle of a complex sample, atan2(imag, real), as a
// signed binary angle in which 2^23 stands for pi; a zero sample gives 0 and
// the negative real axis gives +pi. The angle comes from a vectoring CORDIC
// built as a chain of 32 iteration cells between an entry stage that handles
// the quadrant and an output stage that rounds and saturates. Every stage
// holds one sample, so a new sample is taken on every clock while the output
// is not stalled. Each stage passes a sample on as soon as its neighbor has
// room, so bubbles close up under backpressure and in_tready is high in
// every cycle in which out_tready is high or at least one of the 34 stages
// is empty.
`default_nettype none

module complex_phase_angle (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // fields from bit 0: real_part, imag_part
  input  logic [cpa_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // fields from bit 0: phase, then zero padding
  output logic [cpa_pkg::OUT_DATA_W-1:0] out_tdata
);
  import cpa_pkg::*;

  vec_t                chain_vec [ITERATIONS+1];
  logic [ITERATIONS:0] chain_valid;
  logic [ITERATIONS:0] chain_ready;
  logic [PHASE_W-1:0]  phase;

  cpa_prerot u_prerot (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .re        ($signed(in_tdata[SAMPLE_WIDTH-1:0])),
    .im        ($signed(in_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH])),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_vec   (chain_vec[0])
  );

  for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
    cpa_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .idx       (IDX_W'(k)),
      .in_valid  (chain_valid[k]),
      .in_ready  (chain_ready[k]),
      .in_vec    (chain_vec[k]),
      .out_valid (chain_valid[k+1]),
      .out_ready (chain_ready[k+1]),
      .out_vec   (chain_vec[k+1])
    );
  end

  cpa_round u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chain_valid[ITERATIONS]),
    .in_ready  (chain_ready[ITERATIONS]),
    .in_vec    (chain_vec[ITERATIONS]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .phase     (phase)
  );

  assign out_tdata = OUT_DATA_W'(phase);

endmodule

`default_nettype wire

@@ sv/cpa_checker.sv @@
`default_nettype none

module cpa_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [cpa_pkg::OUT_DATA_W-1:0] out_tdata
);
  import cpa_pkg::*;

  logic signed [PHASE_W-1:0] ph;

  assign ph = $signed(out_tdata[PHASE_W-1:0]);

  // A result is held until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // The angle never leaves [-pi, pi] and the padding stays zero.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (ph <= PI_PHASE) && (ph >= -PI_PHASE) &&
                   ((out_tdata >> PHASE_W) == 0))
    else $error("phase out of range");

  // With the output side ready every stage can move, so the input is open.
  a_ready_through: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input blocked while output ready");

  // No result appears in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result right after reset");

endmodule

bind complex_phase_angle cpa_checker u_cpa_checker (.*);

`default_nettype wire
